// File: design/fru_type_length_field_decoder_macros.svh
// assertion macros shared by the decoder rtl
`ifndef FRU_TYPE_LENGTH_FIELD_DECODER_MACROS_SVH
`define FRU_TYPE_LENGTH_FIELD_DECODER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define FRU_ASSERT_IMPLIES(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed in fru type/length decoder");

// next-cycle implication, checked on every rising edge out of reset
`define FRU_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed in fru type/length decoder");

`endif

// File: design/frutl_pkg.sv
`timescale 1ns / 1ps

package frutl_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_END_FIELDS = 2'd2
    } kind_t;

    // field type codes
    localparam logic [1:0] TYPE_BINARY = 2'd0;
    localparam logic [1:0] TYPE_BCD    = 2'd1;
    localparam logic [1:0] TYPE_ASCII6 = 2'd2;
    localparam logic [1:0] TYPE_TEXT   = 2'd3;

    // header byte that closes the field list
    localparam logic [7:0] END_OF_FIELDS_HDR = 8'hC1;
    // offset added to a six-bit code
    localparam logic [7:0] ASCII6_OFFSET     = 8'h20;
    // number of result slots per input item
    localparam int         MAX_RESULTS       = 3;
    localparam int         MAX_FIELD_RESET   = 255;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic [1:0]  ftype;
    } result_t;

    // bcd-plus character for one nibble
    function automatic logic [7:0] bcd_char(input logic [3:0] code);
        logic [7:0] c;
        case (code)
            4'hA:    c = 8'h20;
            4'hB:    c = 8'h2D;
            4'hC:    c = 8'h2E;
            4'hD, 4'hE, 4'hF: c = 8'h00;
            default: c = 8'h30 + {4'd0, code};
        endcase
        return c;
    endfunction

endpackage

// File: design/fru_type_length_field_decoder.sv
`timescale 1ns / 1ps
`include "fru_type_length_field_decoder_macros.svh"

// Decodes a stream of IPMI FRU type/length coded fields, one encoded byte per
// input item, into character, field-end and end-of-fields result items. Each
// byte is decoded in the cycle it is accepted and its results (zero to three)
// land in a three-slot result buffer that drains one item per cycle while
// m_tready is high. A byte with results holds the input until the buffer has
// drained, since the next byte is accepted in the cycle the buffer's last
// result is taken. max_field_chars is written on the cfg port, which is always
// ready, and resets to 255.
module fru_type_length_field_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_field_chars
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] restart
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_out, [9:8] field_type, [15:10] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last result of this input item
);

    // decoder state
    logic        cfg_write;
    logic [7:0]  max_chars_reg;
    logic        expect_hdr_reg, expect_hdr_next;
    logic        finished_reg, finished_next;
    logic [1:0]  cur_type_reg, cur_type_next;
    logic [5:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  pack_pos_reg, pack_pos_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [7:0]  emitted_reg, emitted_next;

    // result buffer
    frutl_pkg::result_t slot_reg [frutl_pkg::MAX_RESULTS];
    frutl_pkg::result_t slot_next [frutl_pkg::MAX_RESULTS];
    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  n_new;

    logic        accept;
    logic        take;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // handshake
    assign m_tvalid = (rem_reg != 2'd0);
    assign take     = m_tvalid & m_tready;
    assign s_tready = (rem_reg == 2'd0) || (take && rem_reg == 2'd1);
    assign accept   = s_tvalid & s_tready;

    // output payload
    assign m_tdata = {6'd0, slot_reg[0].ftype, slot_reg[0].ch};
    assign m_tuser = slot_reg[0].kind;
    assign m_tlast = (rem_reg == 2'd1);

    // decode of one byte against the current state
    always_comb
    begin
        logic       fin;
        logic       eh;
        logic       ca, cb, cf;
        logic [7:0] cha, chb;
        logic [1:0] ftype_f;
        frutl_pkg::kind_t kind_f;
        logic [7:0] ce;
        logic [5:0] left_dec;
        logic [1:0] idx;
        frutl_pkg::result_t r;

        expect_hdr_next = expect_hdr_reg;
        finished_next   = finished_reg;
        cur_type_next   = cur_type_reg;
        bytes_left_next = bytes_left_reg;
        pack_pos_next   = pack_pos_reg;
        prev_byte_next  = prev_byte_reg;
        emitted_next    = emitted_reg;

        fin      = s_tuser ? 1'b0 : finished_reg;
        eh       = s_tuser ? 1'b1 : expect_hdr_reg;
        ca       = 1'b0;
        cb       = 1'b0;
        cf       = 1'b0;
        cha      = 8'd0;
        chb      = 8'd0;
        ftype_f  = cur_type_reg;
        kind_f   = frutl_pkg::KIND_FIELD_END;
        ce       = emitted_reg;
        left_dec = bytes_left_reg - 6'd1;

        finished_next   = fin;
        expect_hdr_next = eh;

        if (fin)
        begin
            // ignored after end of fields
        end
        else if (eh)
        begin
            // header byte
            if (s_tdata == frutl_pkg::END_OF_FIELDS_HDR)
            begin
                cf            = 1'b1;
                kind_f        = frutl_pkg::KIND_END_FIELDS;
                ftype_f       = frutl_pkg::TYPE_TEXT;
                finished_next = 1'b1;
            end
            else if (s_tdata[5:0] == 6'd0)
            begin
                cf            = 1'b1;
                ftype_f       = s_tdata[7:6];
                cur_type_next = s_tdata[7:6];
            end
            else
            begin
                cur_type_next   = s_tdata[7:6];
                bytes_left_next = s_tdata[5:0];
                pack_pos_next   = 2'd0;
                emitted_next    = 8'd0;
                expect_hdr_next = 1'b0;
            end
        end
        else
        begin
            // data byte: up to two candidate characters
            case (cur_type_reg)
                frutl_pkg::TYPE_BCD:
                begin
                    ca  = 1'b1;
                    cb  = 1'b1;
                    cha = frutl_pkg::bcd_char(s_tdata[3:0]);
                    chb = frutl_pkg::bcd_char(s_tdata[7:4]);
                end
                frutl_pkg::TYPE_ASCII6:
                begin
                    ca = 1'b1;
                    case (pack_pos_reg)
                        2'd0:
                        begin
                            cha           = {2'd0, s_tdata[5:0]} + frutl_pkg::ASCII6_OFFSET;
                            pack_pos_next = 2'd1;
                        end
                        2'd1:
                        begin
                            cha = {2'd0, s_tdata[3:0], prev_byte_reg[7:6]}
                                  + frutl_pkg::ASCII6_OFFSET;
                            pack_pos_next = 2'd2;
                        end
                        default:
                        begin
                            cb  = 1'b1;
                            cha = {2'd0, s_tdata[1:0], prev_byte_reg[7:4]}
                                  + frutl_pkg::ASCII6_OFFSET;
                            chb = {2'd0, s_tdata[7:2]} + frutl_pkg::ASCII6_OFFSET;
                            pack_pos_next = 2'd0;
                        end
                    endcase
                end
                default:
                begin
                    ca  = 1'b1;
                    cha = s_tdata;
                end
            endcase

            // character limit
            if (ca)
            begin
                if (ce < max_chars_reg)
                    ce = ce + 8'd1;
                else
                    ca = 1'b0;
            end
            if (cb)
            begin
                if (ce < max_chars_reg)
                    ce = ce + 8'd1;
                else
                    cb = 1'b0;
            end
            emitted_next    = ce;
            prev_byte_next  = s_tdata;
            bytes_left_next = left_dec;
            if (left_dec == 6'd0)
            begin
                cf              = 1'b1;
                expect_hdr_next = 1'b1;
            end
        end

        // pack the results in order
        for (int i = 0; i < frutl_pkg::MAX_RESULTS; i++)
        begin
            slot_next[i] = '{kind: frutl_pkg::KIND_CHAR, ch: 8'd0, ftype: 2'd0};
        end
        idx = 2'd0;
        if (ca)
        begin
            r.kind  = frutl_pkg::KIND_CHAR;
            r.ch    = cha;
            r.ftype = cur_type_reg;
            slot_next[idx] = r;
            idx = idx + 2'd1;
        end
        if (cb)
        begin
            r.kind  = frutl_pkg::KIND_CHAR;
            r.ch    = chb;
            r.ftype = cur_type_reg;
            slot_next[idx] = r;
            idx = idx + 2'd1;
        end
        if (cf)
        begin
            r.kind  = kind_f;
            r.ch    = 8'd0;
            r.ftype = ftype_f;
            slot_next[idx] = r;
            idx = idx + 2'd1;
        end
        n_new = idx;
    end

    // buffer fill count
    always_comb
    begin
        rem_next = rem_reg;
        if (accept && n_new != 2'd0)
            rem_next = n_new;
        else if (take)
            rem_next = rem_reg - 2'd1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg  <= 8'(frutl_pkg::MAX_FIELD_RESET);
            expect_hdr_reg <= 1'b1;
            finished_reg   <= 1'b0;
            cur_type_reg   <= 2'd0;
            bytes_left_reg <= 6'd0;
            pack_pos_reg   <= 2'd0;
            prev_byte_reg  <= 8'd0;
            emitted_reg    <= 8'd0;
            rem_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_write)
                max_chars_reg <= cfg_data;
            if (accept)
            begin
                expect_hdr_reg <= expect_hdr_next;
                finished_reg   <= finished_next;
                cur_type_reg   <= cur_type_next;
                bytes_left_reg <= bytes_left_next;
                pack_pos_reg   <= pack_pos_next;
                prev_byte_reg  <= prev_byte_next;
                emitted_reg    <= emitted_next;
            end
            rem_reg <= rem_next;
        end
    end

    // result slots: load on a new item, shift down as results are taken
    always_ff @(posedge clk)
    begin
        if (accept && n_new != 2'd0)
        begin
            for (int i = 0; i < frutl_pkg::MAX_RESULTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < frutl_pkg::MAX_RESULTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

    // end-of-fields marker is typed text and closes its item
    `FRU_ASSERT_IMPLIES(a_end_fields_form,
        m_tvalid && m_tuser == frutl_pkg::KIND_END_FIELDS,
        m_tdata[9:8] == frutl_pkg::TYPE_TEXT && m_tlast)
    // non-character results carry a zero character
    `FRU_ASSERT_IMPLIES(a_marker_zero_char,
        m_tvalid && m_tuser != frutl_pkg::KIND_CHAR, m_tdata[7:0] == 8'd0)
    // a taken last result with no new item empties the buffer
    `FRU_ASSERT_NEXT(a_drain_empty,
        take && m_tlast && !accept, !m_tvalid)
    // while results are pending no input is taken unless the last one leaves
    `FRU_ASSERT_IMPLIES(a_no_overrun,
        accept && rem_reg != 2'd0, take && rem_reg == 2'd1)

endmodule

// File: tb/fru_decoder_checker.sv
`timescale 1ns / 1ps

// watches the decoder channels, predicts the result items of every accepted
// byte and compares them in order against what the decoder delivers
module fru_decoder_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] restart
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] char_out, [9:8] field_type, [15:10] zero
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,
    output int          error_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct {
        frutl_pkg::kind_t kind;
        logic [7:0]       ch;
        logic [1:0]       ftype;
        logic             last;
    } decoded_item_t;

    // results still owed by the decoder, oldest first
    decoded_item_t owed_results[$];
    // results of the byte being decoded
    decoded_item_t byte_results[$];

    // shadow of the decoder state
    logic [7:0] char_limit;
    logic       hdr_wanted;
    logic       fields_closed;
    logic [1:0] fld_type;
    logic [5:0] remaining;
    logic [1:0] pack_phase;
    logic [7:0] prior_byte;
    logic [7:0] emitted;

    function automatic logic [7:0] bcd_plus_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'hA)
            c = 8'h30 + {4'h0, nib};
        else if (nib == 4'hA)
            c = 8'h20;
        else if (nib == 4'hB)
            c = 8'h2D;
        else if (nib == 4'hC)
            c = 8'h2E;
        else
            c = 8'h00;
        return c;
    endfunction

    task automatic add_result(input frutl_pkg::kind_t k, input logic [7:0] c,
                              input logic [1:0] t);
        decoded_item_t r;
        r.kind  = k;
        r.ch    = c;
        r.ftype = t;
        r.last  = 1'b0;
        byte_results.push_back(r);
    endtask

    // characters past the limit are decoded but dropped
    task automatic add_char(input logic [7:0] c);
        if (emitted < char_limit)
        begin
            add_result(frutl_pkg::KIND_CHAR, c, fld_type);
            emitted = emitted + 8'd1;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        byte_results.delete();
        if (restart)
        begin
            fields_closed = 1'b0;
            hdr_wanted    = 1'b1;
        end
        if (!fields_closed)
        begin
            if (hdr_wanted)
            begin
                // header byte
                if (b == frutl_pkg::END_OF_FIELDS_HDR)
                begin
                    add_result(frutl_pkg::KIND_END_FIELDS, 8'h00, frutl_pkg::TYPE_TEXT);
                    fields_closed = 1'b1;
                end
                else if (b[5:0] == 6'd0)
                begin
                    fld_type = b[7:6];
                    add_result(frutl_pkg::KIND_FIELD_END, 8'h00, b[7:6]);
                end
                else
                begin
                    fld_type   = b[7:6];
                    remaining  = b[5:0];
                    pack_phase = 2'd0;
                    emitted    = 8'd0;
                    hdr_wanted = 1'b0;
                end
            end
            else
            begin
                // data byte
                case (fld_type)
                    frutl_pkg::TYPE_BCD:
                    begin
                        add_char(bcd_plus_char(b[3:0]));
                        add_char(bcd_plus_char(b[7:4]));
                    end
                    frutl_pkg::TYPE_ASCII6:
                    begin
                        case (pack_phase)
                            2'd0:
                            begin
                                add_char({2'b00, b[5:0]} + frutl_pkg::ASCII6_OFFSET);
                                pack_phase = 2'd1;
                            end
                            2'd1:
                            begin
                                add_char({2'b00, b[3:0], prior_byte[7:6]}
                                         + frutl_pkg::ASCII6_OFFSET);
                                pack_phase = 2'd2;
                            end
                            default:
                            begin
                                add_char({2'b00, b[1:0], prior_byte[7:4]}
                                         + frutl_pkg::ASCII6_OFFSET);
                                add_char({2'b00, b[7:2]} + frutl_pkg::ASCII6_OFFSET);
                                pack_phase = 2'd0;
                            end
                        endcase
                    end
                    default:
                        add_char(b);
                endcase
                prior_byte = b;
                remaining  = remaining - 6'd1;
                if (remaining == 6'd0)
                begin
                    add_result(frutl_pkg::KIND_FIELD_END, 8'h00, fld_type);
                    hdr_wanted = 1'b1;
                end
            end
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i])
            owed_results.push_back(byte_results[i]);
    endtask

    task automatic note_mismatch(input string what, input decoded_item_t e);
        if (error_count < 10)
            $display("%0t mismatch (%s): expected kind %0d char %h type %0d last %0d,",
                     $realtime, what, e.kind, e.ch, e.ftype, e.last,
                     " got kind %0d data %h last %0d", m_tuser, m_tdata, m_tlast);
        error_count = error_count + 1;
    endtask

    // compare delivered results first, then predict the byte taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        decoded_item_t e;
        if (!rst_n)
        begin
            char_limit    = 8'(frutl_pkg::MAX_FIELD_RESET);
            hdr_wanted    = 1'b1;
            fields_closed = 1'b0;
            fld_type      = frutl_pkg::TYPE_BINARY;
            remaining     = 6'd0;
            pack_phase    = 2'd0;
            prior_byte    = 8'h00;
            emitted       = 8'd0;
            owed_results.delete();
            error_count   = 0;
            result_count  = 0;
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count = result_count + 1;
                if (owed_results.size() == 0)
                begin
                    e.kind  = frutl_pkg::KIND_CHAR;
                    e.ch    = 8'h00;
                    e.ftype = frutl_pkg::TYPE_BINARY;
                    e.last  = 1'b0;
                    note_mismatch("result with none pending", e);
                end
                else
                begin
                    e = owed_results.pop_front();
                    if (m_tuser != e.kind || m_tdata != {6'd0, e.ftype, e.ch} ||
                        m_tlast != e.last)
                        note_mismatch("field", e);
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tuser);
            // a limit written at this edge applies from the next byte on
            if (cfg_valid && cfg_ready)
                char_limit = cfg_data;
            pending_count = owed_results.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] in_byte
    logic        s_tuser   = 1'b0;    // [0] restart
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [7:0] char_out, [9:8] field_type, [15:10] zero
    logic [1:0]  m_tuser;             // [1:0] kind
    logic        m_tlast;

    int error_count;
    int pending_count;
    int result_count;

    int bytes_sent = 0;
    int limit_writes = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold = 0;

    fru_type_length_field_decoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    fru_decoder_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(10, 40);
        else if (r < 40)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end
        else if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 99) < 30)
                rx_hold <= pick_gap();
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic restart, input bit counted);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (counted)
            bytes_sent = bytes_sent + 1;
    endtask

    // hold off until every owed result has come, then let a header settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_char_limit(input logic [7:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        limit_writes = limit_writes + 1;
    endtask

    // one header plus its data bytes, now and then cut short
    task automatic send_field(input logic restart);
        logic [7:0] hdr;
        int         len;
        int         n_data;
        if ($urandom_range(0, 99) < 10)
            len = $urandom_range(0, 63);
        else
            len = $urandom_range(0, 7);
        hdr = {2'($urandom_range(0, 3)), 6'(len)};
        n_data = (hdr == frutl_pkg::END_OF_FIELDS_HDR) ? 0 : len;
        if (n_data > 0 && $urandom_range(0, 99) < 8)
            n_data = $urandom_range(0, n_data - 1);
        send_byte(hdr, restart, 1'b1);
        repeat (n_data) send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_phase(input int n_bytes);
        int stop_at;
        int n_fields;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            tx_steady = ($urandom_range(0, 99) < 15);
            rx_steady = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 3)
                drain_results();
            if ($urandom_range(0, 99) < 80)
            begin
                // record of fields, some cut short, maybe closed by the end marker
                n_fields = $urandom_range(1, 4);
                for (int f = 0; f < n_fields; f++)
                    send_field(f == 0);
                if ($urandom_range(0, 99) < 30)
                begin
                    send_byte(frutl_pkg::END_OF_FIELDS_HDR, 1'b0, 1'b1);
                    repeat ($urandom_range(0, 3))
                        send_byte(8'($urandom), 1'b0, 1'b0);
                end
            end
            else
            begin
                // noise
                send_byte(8'($urandom), ($urandom_range(0, 99) < 20), 1'b1);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        logic [7:0] mid_limit;
        logic [7:0] any_limit;
        mid_limit = 8'($urandom_range(2, 10));
        any_limit = 8'($urandom_range(0, 255));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty fields of every type
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h40, 1'b0, 1'b1);
        send_byte(8'h80, 1'b0, 1'b1);
        send_byte(8'hC0, 1'b0, 1'b1);
        // binary extremes
        send_byte(8'h02, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        // text, with a data byte equal to the end marker
        send_byte(8'hC2, 1'b0, 1'b1);
        send_byte(8'h41, 1'b0, 1'b1);
        send_byte(frutl_pkg::END_OF_FIELDS_HDR, 1'b0, 1'b1);
        // bcd-plus over digits 0, 1, 8, 9 and codes A to F
        send_byte(8'h45, 1'b0, 1'b1);
        send_byte(8'h10, 1'b0, 1'b1);
        send_byte(8'h98, 1'b0, 1'b1);
        send_byte(8'hBA, 1'b0, 1'b1);
        send_byte(8'hDC, 1'b0, 1'b1);
        send_byte(8'hFE, 1'b0, 1'b1);
        // full six-bit group
        send_byte(8'h83, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b1);
        // short six-bit field
        send_byte(8'h82, 1'b0, 1'b1);
        send_byte(8'h3F, 1'b0, 1'b1);
        send_byte(8'hC0, 1'b0, 1'b1);
        // restart mid-field into end of fields, then ignored bytes
        send_byte(8'h05, 1'b0, 1'b1);
        send_byte(8'h11, 1'b0, 1'b1);
        send_byte(frutl_pkg::END_OF_FIELDS_HDR, 1'b1, 1'b1);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hC0, 1'b1, 1'b1);

        // random traffic under several character limits
        write_char_limit(8'd0);
        run_phase(76);
        write_char_limit(8'd1);
        run_phase(76);
        write_char_limit(8'd255);
        run_phase(76);
        write_char_limit(mid_limit);
        run_phase(76);
        write_char_limit(any_limit);
        run_phase(76);

        drain_results();
        repeat (10) @(posedge clk);
        $display("tb_top: %0d bytes sent, %0d results checked, %0d limit writes",
                 bytes_sent, result_count, limit_writes);
        $display("tb_top: character limits 0, 1, 255, %0d and %0d", mid_limit, any_limit);
        if (error_count == 0 && pending_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
